// ===== src/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// SM3 package
// Types, constants and round helper functions shared by the SM3 hash block.
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam int WordW     = 32;
    localparam int WinDepth  = 16;
    localparam int NumRounds = 64;
    localparam int DigWords  = 8;

    localparam logic [31:0] TjLow  = 32'h79CC4519;
    localparam logic [31:0] TjHigh = 32'h7A879D8A;
    localparam logic [31:0] PadWord = 32'h80000000;
    localparam logic [7:0]  PadByte = 8'h80;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] state8_t;

    localparam state8_t Iv = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } sm3_state_t;

    // control from sequencer to round core
    typedef struct packed {
        logic       load;
        logic       step;
        logic       fold;
        logic       init;
        logic       push;
        word_t      push_word;
        logic [5:0] round;
    } core_ctrl_t;

    function automatic word_t rotl(input word_t x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// ===== src/sm3_hash.sv =====
// Non-final words are taken one per cycle while no block is being compressed; a word
// that fills a block starts compression. Final word: padding words one per cycle,
// one or two blocks (64 rounds through the shared round unit plus the fold), then
// the eight digest words, which the receiver can stall.
// Reset: asynchronous; chaining value returns to the SM3 IV, counters clear.
// ----------------------------------------------------------------------------
// SM3 hash top level
// Streams message words in and returns the 256-bit digest as eight words.
// ----------------------------------------------------------------------------
module sm3_hash
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] msg_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);

    core_ctrl_t ctrl;
    state8_t    cv;

    sm3_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .msg_word    (msg_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .digest_last (digest_last),
        .cv          (cv),
        .ctrl        (ctrl)
    );

    sm3_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .cv    (cv)
    );

endmodule

// ===== src/sm3_core.sv =====
// ----------------------------------------------------------------------------
// SM3 round core
// Message window with rolling expansion, working registers, one round per
// cycle, and the chaining value.
// ----------------------------------------------------------------------------
module sm3_core
    import sm3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  core_ctrl_t ctrl,
    output state8_t    cv
);

    word_t   win_reg [WinDepth];
    word_t   win_next[WinDepth];
    state8_t r_reg, r_next;
    state8_t cv_reg, cv_next;

    word_t w0, w4, wn, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    logic  early;

    assign cv = cv_reg;

    always_comb
    begin
        early = (ctrl.round < 6'd16);
        tj    = early ? TjLow : TjHigh;
        w0    = win_reg[0];
        w4    = win_reg[4];
        wn    = perm1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
                ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];
        a12   = rotl(r_reg[0], 5'd12);
        ss1   = rotl(a12 + r_reg[4] + rotl(tj, ctrl.round[4:0]), 5'd7);
        ss2   = ss1 ^ a12;
        ff    = early ? (r_reg[0] ^ r_reg[1] ^ r_reg[2])
                      : ((r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2])
                         | (r_reg[1] & r_reg[2]));
        gg    = early ? (r_reg[4] ^ r_reg[5] ^ r_reg[6])
                      : ((r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]));
        tt1   = ff + r_reg[3] + ss2 + (w0 ^ w4);
        tt2   = gg + r_reg[7] + ss1 + w0;

        for (int i = 0; i < WinDepth; i++)
            win_next[i] = win_reg[i];
        r_next  = r_reg;
        cv_next = cv_reg;

        if (ctrl.push || ctrl.step)
        begin
            for (int i = 0; i < WinDepth - 1; i++)
                win_next[i] = win_reg[i + 1];
            win_next[WinDepth - 1] = ctrl.push ? ctrl.push_word : wn;
        end
        if (ctrl.load)
            r_next = cv_reg;
        if (ctrl.step)
        begin
            r_next[3] = r_reg[2];
            r_next[2] = rotl(r_reg[1], 5'd9);
            r_next[1] = r_reg[0];
            r_next[0] = tt1;
            r_next[7] = r_reg[6];
            r_next[6] = rotl(r_reg[5], 5'd19);
            r_next[5] = r_reg[4];
            r_next[4] = perm0(tt2);
        end
        if (ctrl.fold)
            cv_next = cv_reg ^ r_reg;
        if (ctrl.init)
            cv_next = Iv;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WinDepth; i++)
            win_reg[i] <= win_next[i];
        r_reg <= r_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg <= Iv;
        else
            cv_reg <= cv_next;
    end

endmodule

// ===== src/sm3_ctrl.sv =====
// ----------------------------------------------------------------------------
// SM3 sequencer
// Takes message words, counts length, inserts padding, steps the rounds and
// hands out the digest words.
// ----------------------------------------------------------------------------
module sm3_ctrl
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] msg_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last,
    input  state8_t     cv,
    output core_ctrl_t  ctrl
);

    sm3_state_t  state_reg, state_next;
    logic [63:0] bits_reg, bits_next;
    logic [3:0]  pos_reg, pos_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        pad_reg, pad_next;      // message ended, padding in progress
    logic        p80_reg, p80_next;      // 0x80 word still owed
    logic        len_reg, len_next;      // length high word written
    logic        fin_reg, fin_next;      // length words written

    logic        acc;
    logic [2:0]  nb;
    word_t       keep, lastw, pw;

    assign acc         = in_valid && !in_stall;
    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = cv[oidx_reg];
    assign word_index  = oidx_reg;
    assign digest_last = (oidx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bits_reg  <= '0;
            pos_reg   <= '0;
            rnd_reg   <= '0;
            oidx_reg  <= '0;
            pad_reg   <= 1'b0;
            p80_reg   <= 1'b0;
            len_reg   <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bits_reg  <= bits_next;
            pos_reg   <= pos_next;
            rnd_reg   <= rnd_next;
            oidx_reg  <= oidx_next;
            pad_reg   <= pad_next;
            p80_reg   <= p80_next;
            len_reg   <= len_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        bits_next  = bits_reg;
        pos_next   = pos_reg;
        rnd_next   = rnd_reg;
        oidx_next  = oidx_reg;
        pad_next   = pad_reg;
        p80_next   = p80_reg;
        len_next   = len_reg;
        fin_next   = fin_reg;
        in_stall   = 1'b1;
        ctrl       = '0;
        ctrl.round = rnd_reg[5:0];

        nb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        case (nb)
            3'd0:    keep = 32'h00000000;
            3'd1:    keep = 32'hFF000000;
            3'd2:    keep = 32'hFFFF0000;
            3'd3:    keep = 32'hFFFFFF00;
            default: keep = 32'hFFFFFFFF;
        endcase
        case (nb)
            3'd0:    lastw = {PadByte, 24'd0};
            3'd1:    lastw = (msg_word & keep) | {8'd0, PadByte, 16'd0};
            3'd2:    lastw = (msg_word & keep) | {16'd0, PadByte, 8'd0};
            3'd3:    lastw = (msg_word & keep) | {24'd0, PadByte};
            default: lastw = msg_word;
        endcase

        if (p80_reg)
            pw = PadWord;
        else if (pos_reg == 4'd14)
            pw = bits_reg[63:32];
        else if (pos_reg == 4'd15 && len_reg)
            pw = bits_reg[31:0];
        else
            pw = '0;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.push = 1'b1;
                    pos_next  = pos_reg + 4'd1;
                    if (!last_word)
                    begin
                        ctrl.push_word = msg_word;
                        bits_next      = bits_reg + 64'd32;
                    end
                    else
                    begin
                        ctrl.push_word = lastw;
                        bits_next      = bits_reg + {58'd0, nb, 3'd0};
                        pad_next       = 1'b1;
                        p80_next       = (nb == 3'd4);
                    end
                    if (pos_reg == 4'd15)
                    begin
                        ctrl.load  = 1'b1;
                        rnd_next   = '0;
                        state_next = ST_COMP;
                    end
                    else if (last_word)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                ctrl.push      = 1'b1;
                ctrl.push_word = pw;
                pos_next       = pos_reg + 4'd1;
                p80_next       = 1'b0;
                if (pos_reg == 4'd14 && !p80_reg)
                    len_next = 1'b1;
                if (pos_reg == 4'd15 && len_reg)
                    fin_next = 1'b1;
                if (pos_reg == 4'd15)
                begin
                    ctrl.load  = 1'b1;
                    rnd_next   = '0;
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                if (rnd_reg == 7'(NumRounds))
                begin
                    ctrl.fold = 1'b1;
                    rnd_next  = '0;
                    if (fin_reg)
                    begin
                        oidx_next  = '0;
                        state_next = ST_OUT;
                    end
                    else if (pad_reg)
                        state_next = ST_PAD;
                    else
                        state_next = ST_IDLE;
                end
                else
                begin
                    ctrl.step = 1'b1;
                    rnd_next  = rnd_reg + 7'd1;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        ctrl.init  = 1'b1;
                        bits_next  = '0;
                        pos_next   = '0;
                        pad_next   = 1'b0;
                        p80_next   = 1'b0;
                        len_next   = 1'b0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (!acc && state_reg == ST_IDLE)
        begin
            ctrl.push = 1'b0;
            ctrl.load = 1'b0;
        end
    end

endmodule

// ===== bench/sm3_hash_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 digest checker
// Watches both channels of the hash block, recomputes each digest from the
// accepted message words and compares every returned digest word in order.
// ----------------------------------------------------------------------------
module sm3_hash_checker
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] msg_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        digest_last,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        word_t      dword;
        logic [2:0] idx;
        logic       dlast;
    } digest_item_t;

    digest_item_t digest_q[$];
    state8_t      chain;
    word_t        window[16];
    logic [63:0]  msg_bits;
    logic [3:0]   fill;

    function automatic word_t rl(word_t x, int n);
        n = n % 32;
        if (n == 0)
            return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic compress();
        word_t w[68];
        word_t r[8];
        word_t tj, a12, ss1, ss2, ff, gg, tt1, tt2;
        for (int j = 0; j < 16; j++)
            w[j] = window[j];
        for (int j = 16; j < 68; j++)
        begin
            tt1 = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
            w[j] = tt1 ^ rl(tt1, 15) ^ rl(tt1, 23) ^ rl(w[j-13], 7) ^ w[j-6];
        end
        for (int j = 0; j < 8; j++)
            r[j] = chain[j];
        for (int k = 0; k < 64; k++)
        begin
            tj  = (k < 16) ? TjLow : TjHigh;
            a12 = rl(r[0], 12);
            ss1 = rl(a12 + r[4] + rl(tj, k), 7);
            ss2 = ss1 ^ a12;
            ff  = (k < 16) ? (r[0] ^ r[1] ^ r[2])
                           : ((r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]));
            gg  = (k < 16) ? (r[4] ^ r[5] ^ r[6]) : ((r[4] & r[5]) | (~r[4] & r[6]));
            tt1 = ff + r[3] + ss2 + (w[k] ^ w[k+4]);
            tt2 = gg + r[7] + ss1 + w[k];
            r[3] = r[2];
            r[2] = rl(r[1], 9);
            r[1] = r[0];
            r[0] = tt1;
            r[7] = r[6];
            r[6] = rl(r[5], 19);
            r[5] = r[4];
            r[4] = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
        end
        for (int j = 0; j < 8; j++)
            chain[j] ^= r[j];
    endtask

    task automatic absorb(word_t x);
        window[fill] = x;
        fill = fill + 4'd1;
        if (fill == 4'd0)
            compress();
    endtask

    task automatic clear_hash();
        chain    = Iv;
        msg_bits = '0;
        fill     = '0;
    endtask

    task automatic take_word(word_t x, logic [2:0] nb, logic lw);
        int    n;
        word_t keep;
        digest_item_t d;
        if (!lw)
        begin
            msg_bits += 64'd32;
            absorb(x);
            return;
        end
        n = (nb > 3'd4) ? 4 : int'(nb);
        msg_bits += 64'(n * 8);
        if (n == 4)
        begin
            absorb(x);
            absorb(PadWord);
        end
        else
        begin
            keep = (n == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * n));
            absorb((x & keep) | (32'(PadByte) << (24 - 8 * n)));
        end
        while (fill != 4'd14)
            absorb(32'h0);
        absorb(msg_bits[63:32]);
        absorb(msg_bits[31:0]);
        for (int k = 0; k < 8; k++)
        begin
            d.dword = chain[k];
            d.idx   = 3'(k);
            d.dlast = (k == 7);
            digest_q.push_back(d);
        end
        clear_hash();
    endtask

    assign pending = digest_q.size();

    always @(posedge clk)
    begin
        digest_item_t e;
        if (!rst_n)
        begin
            fail_count = 0;
            digest_q.delete();
            clear_hash();
        end
        else
        begin
            if (in_valid && !in_stall)
                take_word(msg_word, valid_bytes, last_word);
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: unexpected digest word %h idx %0d last %0b",
                             $time, digest_word, word_index, digest_last);
                    fail_count++;
                end
                else
                begin
                    e = digest_q.pop_front();
                    if (digest_word !== e.dword || word_index !== e.idx
                        || digest_last !== e.dlast)
                    begin
                        $display("%0t: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                                 $time, e.dword, e.idx, e.dlast,
                                 digest_word, word_index, digest_last);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/sm3_hash_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 hash testbench
// Streams directed and random messages of many lengths through the hash
// block with random idling and back-pressure; the checker compares digests.
// ----------------------------------------------------------------------------
module sm3_hash_tb;
    import sm3_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] msg_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
    int          fail_count;
    int          pending;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_recv;
    int  quiet_cycles;

    sm3_hash dut (.*);

    sm3_hash_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (hold_recv)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_word(logic [31:0] w, logic [2:0] nb, logic lw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        msg_word    <= w;
        valid_bytes <= nb;
        last_word   <= lw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // message of n full words then a last word with nb bytes
    task automatic send_msg(int n, logic [2:0] nb);
        for (int i = 0; i < n; i++)
            send_word($urandom, 3'($urandom_range(7)), 1'b0);
        send_word($urandom, nb, 1'b1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    initial
    begin
        int sent;
        in_valid      = 1'b0;
        msg_word      = '0;
        valid_bytes   = '0;
        last_word     = 1'b0;
        hold_recv     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty message, extremes, padding boundaries
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'hFFFFFFFF, 3'd4, 1'b1);
        send_word(32'h61626300, 3'd3, 1'b1);
        send_word(32'hFFFFFFFF, 3'd7, 1'b1);
        send_word(32'hA5A5A5A5, 3'd1, 1'b1);
        send_word(32'h12345678, 3'd2, 1'b1);
        send_word(32'hFFFFFFFF, 3'd5, 1'b0);
        send_word(32'h00000000, 3'd0, 1'b1);
        send_msg(12, 3'd4);
        send_msg(13, 3'd3);
        drain();

        sent = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 55 : 0;
            recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 38 : 0;
            while (sent < 140 * (ph + 1))
            begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(16, 40)
                                             : $urandom_range(0, 16);
                send_msg(n, 3'($urandom_range(7)));
                sent += n + 1;
            end
            drain();
        end

        // long receiver hold while the sender keeps going
        hold_recv = 1'b1;
        fork
            begin
                repeat (600) @(negedge clk);
                hold_recv = 1'b0;
            end
            begin
                for (int m = 0; m < 3; m++)
                    send_msg(3, 3'd2);
                in_valid <= 1'b0;
                @(negedge clk);
            end
        join
        drain();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
